>>> sv/nmac_pkg.sv
// Package with shared constants, codes and types of the negacyclic multiply-accumulate block.
`default_nettype none
package nmac_pkg;

    // Coefficient field width and the prime modulus.
    localparam int unsigned QW = 23;
    localparam logic [QW-1:0] Q = 23'd8380417;

    // Index field width on the ports and the default polynomial length.
    localparam int unsigned IW = 8;
    localparam int unsigned COEFFS = 256;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MAC   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KSTART,
        ST_KLOAD,
        ST_STREAM,
        ST_DRAIN,
        ST_RSTART,
        ST_REDUCE,
        ST_WRITE,
        ST_RD_ISSUE,
        ST_RD_DATA
    } t_state;

    // Status of the modular reduction unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_red_stat;

endpackage
`default_nettype wire

>>> sv/nmac_if.sv
// Handshake interfaces for the command and the response channel.
`default_nettype none
interface nmac_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic [nmac_pkg::IW-1:0]    coeff_index;
    logic [nmac_pkg::QW-1:0]    matrix_coeff;
    logic [nmac_pkg::QW-1:0]    vector_coeff;

    modport source (output valid, operation, coeff_index, matrix_coeff, vector_coeff,
                    input ready);
    modport sink (input valid, operation, coeff_index, matrix_coeff, vector_coeff,
                  output ready);
endinterface

interface nmac_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [nmac_pkg::QW-1:0]    result_coeff;
    logic [nmac_pkg::IW-1:0]    result_index;

    modport source (output valid, result_coeff, result_index, input ready);
    modport sink (input valid, result_coeff, result_index, output ready);
endinterface
`default_nettype wire

>>> sv/nmac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nmac_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> sv/nmac_mod_unit.sv
// Iterative folding reduction of a wide unsigned sum modulo q.
`default_nettype none
module nmac_mod_unit #(
    parameter int unsigned SUM_W = 55
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [SUM_W-1:0]             i_value,
    output nmac_pkg::t_red_stat               o_stat,
    output logic      [nmac_pkg::QW-1:0]      o_rem
);

    // The modulus is 2^23 - 2^13 + 1, so 2^23 is congruent to 2^13 - 1.
    localparam int unsigned FOLD_SH = 13;

    // Number of folds that bring a value of w bits below 2^(QW+1).
    function automatic int unsigned fold_steps(int unsigned w);
        int unsigned n;
        int unsigned cur;
        n   = 0;
        cur = w;
        while (cur > nmac_pkg::QW + 1) begin
            cur = ((cur - nmac_pkg::QW + FOLD_SH > nmac_pkg::QW) ?
                   cur - nmac_pkg::QW + FOLD_SH : nmac_pkg::QW) + 1;
            n++;
        end
        return n;
    endfunction

    localparam int unsigned FOLDS = fold_steps(SUM_W);
    localparam int unsigned CNT_W = $clog2(FOLDS + 2);

    logic [SUM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] w_hi;
    logic [SUM_W-1:0] w_fold;
    logic             w_ge_q;

    // One fold of the upper bits per cycle, then two compare and subtract steps.
    assign w_hi   = r_rem >> nmac_pkg::QW;
    assign w_fold = (w_hi << FOLD_SH) - w_hi + SUM_W'(r_rem[nmac_pkg::QW-1:0]);
    assign w_ge_q = (r_rem >= SUM_W'(nmac_pkg::Q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and step count.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_cnt <= CNT_W'(FOLDS + 1);
        end else if (r_busy) begin
            if (r_cnt > CNT_W'(1)) begin
                r_rem <= w_fold;
            end else if (w_ge_q) begin
                r_rem <= r_rem - SUM_W'(nmac_pkg::Q);
            end
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem[nmac_pkg::QW-1:0];

endmodule
`default_nettype wire

>>> sv/ntt_negacyclic_poly_mac_top.sv
// Top level of the negacyclic polynomial multiply-accumulate block modulo q.
// Usage: words arrive on the command channel (valid/ready) carrying an operation,
// an index and a matrix and vector coefficient; read results leave on the response
// channel as a coefficient and its index.
// A load writes both reduced coefficients in the accept cycle; a clear empties the
// accumulator in the accept cycle. A read returns its word from the response register.
// A multiply-accumulate forms the product in Z_q[X]/(X^N+1) coefficient by
// coefficient with one pipelined 23x23 multiplier, one product per cycle, then
// reduces each sum modulo q by folding steps and final compare and subtract steps.
// The block takes one word at a time: ready is high only while the sequencer is
// idle and the response register is empty or being taken.
// A response waits in its output register while the receiver stalls.
// Reset is synchronous and active low; it empties the accumulator through per-entry
// valid bits and drops any pending response. Loaded coefficients hold no reset value.
`default_nettype none
module ntt_negacyclic_poly_mac_top #(
    parameter int unsigned COEFFS = nmac_pkg::COEFFS
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    nmac_cmd_if.sink   i_cmd,
    nmac_rsp_if.source o_rsp
);

    localparam int unsigned QW    = nmac_pkg::QW;
    localparam int unsigned IDX_W = $clog2(COEFFS);
    localparam int unsigned SUM_W = 2 * QW + IDX_W + 1;

    nmac_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_rd_idx;
    logic [1:0]       r_drain;
    logic [COEFFS-1:0] r_acc_vld;

    logic             r_v1, r_v2, r_v3, r_neg1;
    logic [QW-1:0]    r_a, r_b;
    logic [2*QW-1:0]  r_prod;
    logic [SUM_W-1:0] r_sum;

    logic             r_out_valid;
    logic [QW-1:0]    r_out_coeff;
    logic [IDX_W-1:0] r_out_idx;

    logic             w_accept;
    logic [IDX_W-1:0] w_idx;
    logic [QW-1:0]    w_mc, w_vc;
    logic [QW-1:0]    w_m_rdata, w_v_rdata, w_acc_rdata;
    logic [IDX_W-1:0] w_acc_raddr;
    logic [IDX_W-1:0] w_v_raddr;
    logic             w_load_we;
    logic             w_acc_we;
    logic             w_issue;
    logic             w_red_start;
    logic [QW-1:0]    w_red_rem;
    nmac_pkg::t_red_stat w_red_stat;

    assign i_cmd.ready = (r_state == nmac_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_idx       = i_cmd.coeff_index[IDX_W-1:0];

    // Reduce loaded values that are at or above q.
    assign w_mc = (i_cmd.matrix_coeff >= nmac_pkg::Q) ? i_cmd.matrix_coeff - nmac_pkg::Q
                                                      : i_cmd.matrix_coeff;
    assign w_vc = (i_cmd.vector_coeff >= nmac_pkg::Q) ? i_cmd.vector_coeff - nmac_pkg::Q
                                                      : i_cmd.vector_coeff;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            nmac_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (nmac_pkg::t_op'(i_cmd.operation))
                        nmac_pkg::OP_MAC:  n_state = nmac_pkg::ST_KSTART;
                        nmac_pkg::OP_READ: n_state = nmac_pkg::ST_RD_ISSUE;
                        default:           n_state = nmac_pkg::ST_IDLE;
                    endcase
                end
            end
            nmac_pkg::ST_KSTART:   n_state = nmac_pkg::ST_KLOAD;
            nmac_pkg::ST_KLOAD:    n_state = nmac_pkg::ST_STREAM;
            nmac_pkg::ST_STREAM: begin
                if (r_i == IDX_W'(COEFFS - 1)) begin
                    n_state = nmac_pkg::ST_DRAIN;
                end
            end
            nmac_pkg::ST_DRAIN: begin
                if (r_drain == 2'd2) begin
                    n_state = nmac_pkg::ST_RSTART;
                end
            end
            nmac_pkg::ST_RSTART:   n_state = nmac_pkg::ST_REDUCE;
            nmac_pkg::ST_REDUCE: begin
                if (w_red_stat.done) begin
                    n_state = nmac_pkg::ST_WRITE;
                end
            end
            nmac_pkg::ST_WRITE: begin
                n_state = (r_k == IDX_W'(COEFFS - 1)) ? nmac_pkg::ST_IDLE
                                                      : nmac_pkg::ST_KSTART;
            end
            nmac_pkg::ST_RD_ISSUE: n_state = nmac_pkg::ST_RD_DATA;
            nmac_pkg::ST_RD_DATA:  n_state = nmac_pkg::ST_IDLE;
            default:               n_state = nmac_pkg::ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_load_we   = w_accept && (nmac_pkg::t_op'(i_cmd.operation) == nmac_pkg::OP_LOAD);
        w_issue     = (r_state == nmac_pkg::ST_STREAM);
        w_red_start = (r_state == nmac_pkg::ST_RSTART);
        w_acc_we    = (r_state == nmac_pkg::ST_WRITE);
        w_acc_raddr = (r_state == nmac_pkg::ST_RD_ISSUE) ? r_rd_idx : r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nmac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Loop counters and the read index.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_k      <= '0;
            r_rd_idx <= w_idx;
        end else if (w_acc_we) begin
            r_k <= r_k + 1'b1;
        end
        if (r_state == nmac_pkg::ST_KSTART) begin
            r_i <= '0;
        end else if (w_issue) begin
            r_i <= r_i + 1'b1;
        end
        if (r_state == nmac_pkg::ST_DRAIN) begin
            r_drain <= r_drain + 1'b1;
        end else begin
            r_drain <= '0;
        end
    end

    // Accumulator valid bits: an entry not valid reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (w_accept &&
                     nmac_pkg::t_op'(i_cmd.operation) == nmac_pkg::OP_CLEAR) begin
            r_acc_vld <= '0;
        end else if (w_acc_we) begin
            r_acc_vld[r_k] <= 1'b1;
        end
    end

    // Coefficient stores and the accumulator.
    assign w_v_raddr = r_k - r_i;

    nmac_ram #(.WIDTH(QW), .DEPTH(COEFFS)) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_idx),
        .i_wdata (w_mc),
        .i_raddr (r_i),
        .o_rdata (w_m_rdata)
    );

    nmac_ram #(.WIDTH(QW), .DEPTH(COEFFS)) u_vector_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_idx),
        .i_wdata (w_vc),
        .i_raddr (w_v_raddr),
        .o_rdata (w_v_rdata)
    );

    nmac_ram #(.WIDTH(QW), .DEPTH(COEFFS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (r_k),
        .i_wdata (w_red_rem),
        .i_raddr (w_acc_raddr),
        .o_rdata (w_acc_rdata)
    );

    // Product pipeline; a wrapped term enters negated as q minus the coefficient.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= (r_i > r_k);
        r_a    <= w_m_rdata;
        r_b    <= r_neg1 ? nmac_pkg::Q - w_v_rdata : w_v_rdata;
        r_prod <= (2 * QW)'(r_a) * (2 * QW)'(r_b);
        if (r_state == nmac_pkg::ST_KLOAD) begin
            r_sum <= r_acc_vld[r_k] ? SUM_W'(w_acc_rdata) : '0;
        end else if (r_v3) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
    end

    nmac_mod_unit #(.SUM_W(SUM_W)) u_mod_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_red_start),
        .i_value (r_sum),
        .o_stat  (w_red_stat),
        .o_rem   (w_red_rem)
    );

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == nmac_pkg::ST_RD_DATA) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == nmac_pkg::ST_RD_DATA) begin
            r_out_coeff <= r_acc_vld[r_rd_idx] ? w_acc_rdata : '0;
            r_out_idx   <= r_rd_idx;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_coeff = r_out_coeff;
    assign o_rsp.result_index = nmac_pkg::IW'(r_out_idx);

endmodule
`default_nettype wire

>>> sim/tb_ntt_negacyclic_poly_mac_top.sv
// Self-checking testbench for the negacyclic polynomial multiply-accumulate block.
`timescale 1ns / 1ps
module tb_ntt_negacyclic_poly_mac_top;

    localparam int unsigned RUN_LIMIT = 4_000_000;
    localparam int unsigned MAC_ROUNDS = 6;
    localparam int unsigned NCOEF = nmac_pkg::COEFFS;
    localparam logic [22:0] QM = nmac_pkg::Q;

    typedef struct {
        nmac_pkg::t_op op;
        logic [7:0]   idx;
        logic [22:0]  mat;
        logic [22:0]  vec;
        bit           fixed;
        logic [22:0]  fixed_coeff;
    } t_dir_row;

    typedef struct {
        logic [22:0] coeff;
        logic [7:0]  index;
    } t_read_word;

    logic i_clk;
    logic i_rst_n;
    nmac_cmd_if cmd();
    nmac_rsp_if rsp();

    ntt_negacyclic_poly_mac_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    // Shadow copy of the stores and the accumulator.
    logic [22:0] mat_shadow [NCOEF];
    logic [22:0] vec_shadow [NCOEF];
    logic [22:0] acc_shadow [NCOEF];
    t_read_word  pending_reads [$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;

    // Directed rows: reads after reset and clear, load extremes.
    t_dir_row dir_rows [10] = '{
        '{nmac_pkg::OP_READ,  8'd0,   23'd0,      23'd0,      1'b1, 23'd0},
        '{nmac_pkg::OP_READ,  8'd255, 23'd0,      23'd0,      1'b1, 23'd0},
        '{nmac_pkg::OP_LOAD,  8'd0,   23'd0,      23'd0,      1'b0, 23'd0},
        '{nmac_pkg::OP_LOAD,  8'd255, QM - 23'd1, QM - 23'd1, 1'b0, 23'd0},
        '{nmac_pkg::OP_LOAD,  8'd1,   QM,         23'h7FFFFF, 1'b0, 23'd0},
        '{nmac_pkg::OP_LOAD,  8'd2,   23'h7FFFFF, QM,         1'b0, 23'd0},
        '{nmac_pkg::OP_LOAD,  8'd3,   23'h555555, 23'h2AAAAA, 1'b0, 23'd0},
        '{nmac_pkg::OP_CLEAR, 8'd0,   23'd0,      23'd0,      1'b0, 23'd0},
        '{nmac_pkg::OP_READ,  8'd128, 23'd0,      23'd0,      1'b1, 23'd0},
        '{nmac_pkg::OP_READ,  8'd0,   23'd0,      23'd0,      1'b1, 23'd0}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("ntt_negacyclic_poly_mac_top verification failed");
            $finish;
        end
    end

    function automatic logic [22:0] reduce_load(logic [22:0] raw);
        return (raw >= QM) ? raw - QM : raw;
    endfunction

    // Negacyclic product of the shadow stores, added into the shadow accumulator.
    function automatic void accumulate_product();
        longint unsigned sums [NCOEF];
        longint unsigned prod;
        int k;
        for (int n = 0; n < NCOEF; n++) sums[n] = 0;
        for (int i = 0; i < NCOEF; i++) begin
            for (int j = 0; j < NCOEF; j++) begin
                prod = (longint'(mat_shadow[i]) * longint'(vec_shadow[j])) % QM;
                k = i + j;
                if (k < NCOEF) sums[k] += prod;
                else sums[k - NCOEF] += (QM - prod) % QM;
            end
        end
        for (int n = 0; n < NCOEF; n++)
            acc_shadow[n] = 23'((longint'(acc_shadow[n]) + sums[n] % QM) % QM);
    endfunction

    // Apply an accepted word to the shadow state; reads queue their expectation.
    function automatic void predict_word(nmac_pkg::t_op op, logic [7:0] idx,
                                         logic [22:0] m, logic [22:0] v, bit fixed,
                                         logic [22:0] fc);
        t_read_word w;
        case (op)
            nmac_pkg::OP_LOAD: begin
                mat_shadow[idx] = reduce_load(m);
                vec_shadow[idx] = reduce_load(v);
            end
            nmac_pkg::OP_MAC: accumulate_product();
            nmac_pkg::OP_READ: begin
                w.coeff = fixed ? fc : acc_shadow[idx];
                w.index = idx;
                pending_reads.push_back(w);
            end
            default: begin
                for (int n = 0; n < NCOEF; n++) acc_shadow[n] = '0;
            end
        endcase
    endfunction

    // Offer one word, in bursts with random gaps, and wait for its acceptance.
    task automatic send_word(nmac_pkg::t_op op, logic [7:0] idx, logic [22:0] m,
                             logic [22:0] v, bit fixed = 1'b0, logic [22:0] fc = '0);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (gap > 0) begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        cmd.valid        <= 1'b1;
        cmd.operation    <= op;
        cmd.coeff_index  <= idx;
        cmd.matrix_coeff <= m;
        cmd.vector_coeff <= v;
        do @(posedge i_clk); while (!cmd.ready);
        predict_word(op, idx, m, v, fixed, fc);
    endtask

    // Receiver: one long hold-off at the start, then a random stall pattern.
    initial begin
        rsp.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        repeat (300) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if ((cycle_count / 500) % 3 == 0) rsp.ready <= 1'b1;
            else rsp.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Response checker.
    always @(posedge i_clk) begin
        t_read_word w;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected read word: coeff %0d index %0d",
                       rsp.result_coeff, rsp.result_index);
                fail_count++;
            end else begin
                w = pending_reads.pop_front();
                if (rsp.result_coeff !== w.coeff) begin
                    $error("result_coeff: expected %0d, actual %0d", w.coeff,
                           rsp.result_coeff);
                    fail_count++;
                end
                if (rsp.result_index !== w.index) begin
                    $error("result_index: expected %0d, actual %0d", w.index,
                           rsp.result_index);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        int unsigned nloads;
        cmd.valid        = 1'b0;
        cmd.operation    = nmac_pkg::OP_LOAD;
        cmd.coeff_index  = '0;
        cmd.matrix_coeff = '0;
        cmd.vector_coeff = '0;
        for (int n = 0; n < NCOEF; n++) begin
            mat_shadow[n] = '0;
            vec_shadow[n] = '0;
            acc_shadow[n] = '0;
        end
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_word(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].mat, dir_rows[r].vec,
                      dir_rows[r].fixed, dir_rows[r].fixed_coeff);

        // Fill every index so that no product touches an unwritten entry.
        for (int n = 0; n < NCOEF; n++)
            send_word(nmac_pkg::OP_LOAD, n[7:0], 23'($urandom), 23'($urandom));

        // Rounds of partial reloads, a product, reads and an occasional clear.
        for (int r = 0; r < MAC_ROUNDS; r++) begin
            send_word(nmac_pkg::OP_MAC, 8'($urandom), 23'($urandom), 23'($urandom));
            repeat ($urandom_range(8, 14))
                send_word(nmac_pkg::OP_READ, 8'($urandom), 23'($urandom),
                          23'($urandom));
            if ($urandom_range(0, 2) == 0) begin
                send_word(nmac_pkg::OP_CLEAR, 8'($urandom), 23'($urandom),
                          23'($urandom));
                send_word(nmac_pkg::OP_READ, 8'($urandom), 23'($urandom),
                          23'($urandom));
            end
            nloads = $urandom_range(5, 20);
            repeat (nloads)
                send_word(nmac_pkg::OP_LOAD, 8'($urandom),
                          ($urandom_range(0, 7) == 0) ?
                              23'h7FFFFF - 23'($urandom_range(0, 8190)) : 23'($urandom),
                          23'($urandom));
        end
        send_word(nmac_pkg::OP_MAC, 8'd0, 23'd0, 23'd0);
        repeat (12)
            send_word(nmac_pkg::OP_READ, 8'($urandom), 23'($urandom), 23'($urandom));
        cmd.valid <= 1'b0;

        wait (pending_reads.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("ntt_negacyclic_poly_mac_top verification clean");
        else
            $display("ntt_negacyclic_poly_mac_top verification failed");
        $finish;
    end

endmodule
